@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the reduction core.
// Defining ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define DWMR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DWMR_ASSERT_NORST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DWMR_ASSERT(lbl, clk, rst_n, prop, msg)
`define DWMR_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

@@ src/dwmr_pkg.sv @@
// ----------------------------------------------------------------------------
// dwmr_pkg
// Shared constants of the double-word modular reduction core.
// ----------------------------------------------------------------------------
`default_nettype none

package dwmr_pkg;

	localparam int WORD_BITS_DEF = 64;

	typedef enum logic {
		REG_DIVISOR    = 1'b0,
		REG_RECIPROCAL = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

@@ src/dwmr_step.sv @@
// ----------------------------------------------------------------------------
// dwmr_step
// One reciprocal reduction step of a two-word value by a normalized divisor,
// cut into eight pipeline stages with a ready chain and a sideband that
// travels with each beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dwmr_step
	import dwmr_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int SIDE_BITS = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [WORD_BITS-1:0] in_u1,
	input  logic [WORD_BITS-1:0] in_u0,
	input  logic [SIDE_BITS-1:0] in_side,
	input  logic [WORD_BITS-1:0] dn,
	input  logic [WORD_BITS-1:0] recip,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_BITS-1:0] out_r,
	output logic [SIDE_BITS-1:0] out_side
);

	localparam int W  = WORD_BITS;
	localparam int DW = 2 * WORD_BITS;
	localparam int HB = (WORD_BITS + 1) / 2;
	localparam int LB = WORD_BITS - HB;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;

	logic [W-1:0]         u1_s1, u0_s1;
	logic [SIDE_BITS-1:0] side_s1;

	logic [2*HB-1:0]      pp0_s2;
	logic [W-1:0]         pp1_s2, pp2_s2;
	logic [2*LB-1:0]      pp3_s2;
	logic [W-1:0]         u1_s2, u0_s2;
	logic [SIDE_BITS-1:0] side_s2;

	logic [DW-1:0]        q_s3;
	logic [W-1:0]         u0_s3;
	logic [SIDE_BITS-1:0] side_s3;

	logic [W-1:0]         q1p_s4, q0_s4, u0_s4;
	logic [SIDE_BITS-1:0] side_s4;

	logic [2*HB-1:0]      m0_s5;
	logic [LB-1:0]        m1_s5, m2_s5;
	logic [W-1:0]         q0_s5, u0_s5;
	logic [SIDE_BITS-1:0] side_s5;

	logic [W-1:0]         r_s6, q0_s6;
	logic [SIDE_BITS-1:0] side_s6;

	logic [W-1:0]         r_s7;
	logic [SIDE_BITS-1:0] side_s7;

	logic [W-1:0]         r_s8;
	logic [SIDE_BITS-1:0] side_s8;

	logic [2*HB-1:0] pp0_c;
	logic [W-1:0]    pp1_c, pp2_c;
	logic [2*LB-1:0] pp3_c;
	logic [DW-1:0]   q_c;
	logic [2*HB-1:0] m0_c;
	logic [LB-1:0]   m1_c, m2_c, msum_c;
	logic [W-1:0]    plo_c;

	always_comb begin
		rdy_s8 = !vld_s8 || out_ready;
		rdy_s7 = !vld_s7 || rdy_s8;
		rdy_s6 = !vld_s6 || rdy_s7;
		rdy_s5 = !vld_s5 || rdy_s6;
		rdy_s4 = !vld_s4 || rdy_s5;
		rdy_s3 = !vld_s3 || rdy_s4;
		rdy_s2 = !vld_s2 || rdy_s3;
		rdy_s1 = !vld_s1 || rdy_s2;
	end

	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
			if (rdy_s8) vld_s8 <= vld_s7;
		end
	end

	// The reciprocal times the high word is formed from four half-word products.
	assign pp0_c = (2*HB)'(recip[HB-1:0]) * (2*HB)'(u1_s1[HB-1:0]);
	assign pp1_c = W'(recip[HB-1:0]) * W'(u1_s1[W-1:HB]);
	assign pp2_c = W'(recip[W-1:HB]) * W'(u1_s1[HB-1:0]);
	assign pp3_c = (2*LB)'(recip[W-1:HB]) * (2*LB)'(u1_s1[W-1:HB]);

	// Adding the dividend words as one double word gives both quotient words.
	assign q_c = (DW'(pp3_s2) << (2 * HB)) + ((DW'(pp1_s2) + DW'(pp2_s2)) << HB)
		+ DW'(pp0_s2) + {u1_s2, u0_s2};

	// Only the low word of the quotient times the divisor is needed.
	assign m0_c   = (2*HB)'(q1p_s4[HB-1:0]) * (2*HB)'(dn[HB-1:0]);
	assign m1_c   = q1p_s4[LB-1:0] * dn[W-1:HB];
	assign m2_c   = q1p_s4[W-1:HB] * dn[LB-1:0];
	assign msum_c = m1_s5 + m2_s5;
	assign plo_c  = W'(m0_s5) + {msum_c, {HB{1'b0}}};

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			u1_s1   <= in_u1;
			u0_s1   <= in_u0;
			side_s1 <= in_side;
		end
		if (rdy_s2) begin
			pp0_s2  <= pp0_c;
			pp1_s2  <= pp1_c;
			pp2_s2  <= pp2_c;
			pp3_s2  <= pp3_c;
			u1_s2   <= u1_s1;
			u0_s2   <= u0_s1;
			side_s2 <= side_s1;
		end
		if (rdy_s3) begin
			q_s3    <= q_c;
			u0_s3   <= u0_s2;
			side_s3 <= side_s2;
		end
		if (rdy_s4) begin
			q1p_s4  <= q_s3[DW-1:W] + W'(1);
			q0_s4   <= q_s3[W-1:0];
			u0_s4   <= u0_s3;
			side_s4 <= side_s3;
		end
		if (rdy_s5) begin
			m0_s5   <= m0_c;
			m1_s5   <= m1_c;
			m2_s5   <= m2_c;
			q0_s5   <= q0_s4;
			u0_s5   <= u0_s4;
			side_s5 <= side_s4;
		end
		if (rdy_s6) begin
			r_s6    <= u0_s5 - plo_c;
			q0_s6   <= q0_s5;
			side_s6 <= side_s5;
		end
		if (rdy_s7) begin
			r_s7    <= (r_s6 >= q0_s6) ? (r_s6 + dn) : r_s6;
			side_s7 <= side_s6;
		end
		if (rdy_s8) begin
			r_s8    <= (r_s7 >= dn) ? (r_s7 - dn) : r_s7;
			side_s8 <= side_s7;
		end
	end

	assign out_valid = vld_s8;
	assign out_r     = r_s8;
	assign out_side  = side_s8;

	logic [7:0] vld_vec;
	assign vld_vec = {vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8};

	`DWMR_ASSERT(a_fill, clk, arst_n, (in_valid && in_ready && !(out_valid && out_ready)) |=> ($countones(vld_vec) == $past($countones(vld_vec)) + 1), "beat accepted but occupancy did not grow")
	`DWMR_ASSERT(a_drain, clk, arst_n, (out_valid && out_ready && !(in_valid && in_ready)) |=> ($countones(vld_vec) + 1 == $past($countones(vld_vec))), "beat delivered but occupancy did not shrink")
	`DWMR_ASSERT(a_noblock, clk, arst_n, out_ready |-> in_ready, "step holds off input while its output drains")

endmodule

`default_nettype wire

@@ src/double_word_mod_reduce_core.sv @@
// A beat passes the input register, both reduction steps and the output register.
// Throughput: one beat per cycle when not stalled; both steps are fully pipelined and
// each 64x64 product is split into 32x32 partial products over two stages.
// Reset: asynchronous, active low; clears all valid bits, sets divisor to 1 and
// the reciprocal to all ones. There is no clearing pass.
// ----------------------------------------------------------------------------
// double_word_mod_reduce_core
// Remainder of a two-word dividend modulo a configured divisor, using a
// precomputed reciprocal of the normalized divisor.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module double_word_mod_reduce_core
	import dwmr_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [WORD_BITS-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WORD_BITS-1:0] dividend_high,
	input  logic [WORD_BITS-1:0] dividend_low,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_BITS-1:0] remainder
);

	localparam int W  = WORD_BITS;
	localparam int NB = $clog2(WORD_BITS);
	localparam int PW = 1 << NB;
	localparam int SW = NB + 1;
	localparam int SIDE_A = 2 * WORD_BITS + 2;

	// Binary search for the leading zeros of a nonzero word.
	function automatic logic [NB-1:0] lead_zeros(input logic [W-1:0] x);
		logic [PW-1:0] t;
		logic [NB-1:0] n;
		t = PW'(x) << (PW - W);
		n = '0;
		for (int k = NB - 1; k >= 0; k--) begin
			if ((t >> (PW - (1 << k))) == '0) begin
				t    = t << (1 << k);
				n[k] = 1'b1;
			end
		end
		return n;
	endfunction

	logic [W-1:0]  divisor_q, recip_q, dn_q;
	logic [NB-1:0] norm_q, norm_c;

	assign norm_c = lead_zeros(divisor_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= W'(1);
			recip_q   <= '1;
			norm_q    <= NB'(W - 1);
			dn_q      <= {1'b1, {(W - 1){1'b0}}};
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIVISOR:    divisor_q <= cfg_data;
					REG_RECIPROCAL: recip_q   <= cfg_data;
				endcase
			end
			norm_q <= norm_c;
			dn_q   <= divisor_q << norm_c;
		end
	end

	logic [SW-1:0] shamt;
	assign shamt = SW'(W) - SW'(norm_q);

	logic         vld_s1, rdy_s1;
	logic [W-1:0] hi_s1, lo_s1;
	logic         need_s1, nz_s1;

	logic a_in_ready, a_out_valid, a_out_ready;
	logic [W-1:0] a_u1, a_u0, a_r;
	logic [SIDE_A-1:0] a_side_in, a_side_out;

	logic         a_nz, a_need;
	logic [W-1:0] a_hsh, a_lo;

	logic b_in_ready, b_out_valid, b_out_ready;
	logic [W-1:0] b_hsh, b_u1, b_u0, b_r;
	logic b_nz;

	logic         vld_s18, rdy_s18;
	logic [W-1:0] rem_s18;

	assign rdy_s1   = !vld_s1 || a_in_ready;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			hi_s1   <= dividend_high;
			lo_s1   <= dividend_low;
			need_s1 <= dividend_high >= divisor_q;
			nz_s1   <= divisor_q != '0;
		end
	end

	assign a_u1      = hi_s1 >> shamt;
	assign a_u0      = hi_s1 << norm_q;
	assign a_side_in = {nz_s1, need_s1, a_u0, lo_s1};

	dwmr_step #(
		.WORD_BITS (WORD_BITS),
		.SIDE_BITS (SIDE_A)
	) u_step_hi (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (a_in_ready),
		.in_u1     (a_u1),
		.in_u0     (a_u0),
		.in_side   (a_side_in),
		.dn        (dn_q),
		.recip     (recip_q),
		.out_valid (a_out_valid),
		.out_ready (a_out_ready),
		.out_r     (a_r),
		.out_side  (a_side_out)
	);

	assign {a_nz, a_need, a_hsh, a_lo} = a_side_out;

	// The reduced high word shifted back up is the remainder with its low bits cleared.
	assign b_hsh       = a_need ? ((a_r >> norm_q) << norm_q) : a_hsh;
	assign b_u1        = b_hsh + (a_lo >> shamt);
	assign b_u0        = a_lo << norm_q;
	assign a_out_ready = b_in_ready;

	dwmr_step #(
		.WORD_BITS (WORD_BITS),
		.SIDE_BITS (1)
	) u_step_lo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_out_valid),
		.in_ready  (b_in_ready),
		.in_u1     (b_u1),
		.in_u0     (b_u0),
		.in_side   (a_nz),
		.dn        (dn_q),
		.recip     (recip_q),
		.out_valid (b_out_valid),
		.out_ready (b_out_ready),
		.out_r     (b_r),
		.out_side  (b_nz)
	);

	assign rdy_s18     = !vld_s18 || !out_stall;
	assign b_out_ready = rdy_s18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s18 <= 1'b0;
		end else if (rdy_s18) begin
			vld_s18 <= b_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s18) begin
			rem_s18 <= b_nz ? (b_r >> norm_q) : '0;
		end
	end

	assign out_valid = vld_s18;
	assign remainder = rem_s18;

	`DWMR_ASSERT(a_dn_top, clk, arst_n, (divisor_q != '0) |=> dn_q[W-1], "normalized divisor lacks its top bit")
	`DWMR_ASSERT(a_dn_back, clk, arst_n, (divisor_q != '0) |=> ((dn_q >> norm_q) == $past(divisor_q)), "normalization shift loses divisor bits")
	`DWMR_ASSERT(a_flow, clk, arst_n, !out_stall |-> !in_stall, "input stalled while the output side drains")

endmodule

`default_nettype wire
